// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker in m2u_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define M2U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also runs while reset is held.
`define M2U_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/m2u_pkg.sv =====
// Types, constants and length tables for the MIDI to USB-MIDI event packetizer.
`timescale 1ns / 1ps

package m2u_pkg;

  localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
  localparam logic [7:0] STATUS_EOX     = 8'hF7;
  localparam logic [7:0] STATUS_SYSTEM  = 8'hF0;
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;
  localparam logic [3:0] CIN_SYSEX      = 4'd4;
  localparam logic [3:0] CIN_REALTIME   = 4'd15;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] event_byte0;
    logic [7:0] event_byte1;
    logic [7:0] event_byte2;
    logic       last_event;
  } pkt_t;

  typedef logic [2:0][7:0] msg_t;

  // Message length of channel messages, indexed by status bits 6:4.
  function automatic logic [1:0] chan_len(input logic [2:0] idx);
    logic [1:0] len;
    unique case (idx)
      3'd4, 3'd5: len = 2'd2;
      3'd7:       len = 2'd0;
      default:    len = 2'd3;
    endcase
    return len;
  endfunction

  // Message length of system messages, indexed by the low nibble.
  function automatic logic [1:0] sys_len(input logic [3:0] idx);
    logic [1:0] len;
    unique case (idx)
      4'h0, 4'h2:                               len = 2'd3;
      4'h1, 4'h3:                               len = 2'd2;
      4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: len = 2'd1;
      default:                                  len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    if (!s[7]) begin
      len = 2'd0;
    end else if (s < STATUS_SYSTEM) begin
      len = chan_len(s[6:4]);
    end else begin
      len = sys_len(s[3:0]);
    end
    return len;
  endfunction

  // Code index of system common messages by index of their last byte.
  function automatic logic [3:0] cin_common(input logic [1:0] idx);
    logic [3:0] cin;
    unique case (idx)
      2'd0:    cin = 4'd5;
      2'd1:    cin = 4'd2;
      default: cin = 4'd3;
    endcase
    return cin;
  endfunction

endpackage

// ===== hdl/midi_to_usb_event_packetizer_core.sv =====
// MIDI byte parser and USB-MIDI event packet queue: top level.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall   | in_rx_byte
//   out     | output    | out_valid/out_stall | out_code_index, out_event_byte0..2,
//           |           |                    | out_last_event
//
// A byte is parsed in the cycle it is accepted and its zero, one or two packets go
// into a four-entry queue at that edge; packets leave at one per cycle while out_stall is low.
// The sustained byte rate is set by the single queue read port: a byte that yields two
// packets fills two queue slots, and only one packet leaves per cycle.
// in_stall is high while fewer than two queue slots are free.
// Synchronous reset clears status, byte count, message buffer and queue.
`timescale 1ns / 1ps

module midi_to_usb_event_packetizer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_code_index,
  output logic [7:0] out_event_byte0,
  output logic [7:0] out_event_byte1,
  output logic [7:0] out_event_byte2,
  output logic       out_last_event
);
  import m2u_pkg::*;

  logic [7:0]        cur_status_r, cur_status_nxt;
  logic [1:0]        byte_count_r, byte_count_nxt;
  msg_t              msg_r, msg_nxt;

  pkt_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  pkt_t              pkt_a, pkt_b;
  logic              emit_a, emit_b;
  pkt_t              push0, push1;
  logic [1:0]        push_n;
  logic              in_fire, out_fire;
  logic [QPTR_W-1:0] wr_ptr_p1;

  // Build the packet for the message held in the buffer.
  function automatic pkt_t make_pkt(input logic [7:0] s, input logic [1:0] bc,
                                    input msg_t mb);
    pkt_t       p;
    logic [1:0] last_idx;
    logic [3:0] code;
    last_idx = (bc == 2'd0) ? 2'd0 : bc - 2'd1;
    if (last_idx > 2'd2) begin
      last_idx = 2'd2;
    end
    if (s < STATUS_SYSTEM) begin
      code = s[7:4];
    end else if (s == STATUS_SYSEX) begin
      code = CIN_SYSEX + ((mb[last_idx] == STATUS_EOX) ? {2'b00, bc} : 4'd0);
    end else if (s < REALTIME_FIRST) begin
      code = cin_common(last_idx);
    end else begin
      code = CIN_REALTIME;
    end
    p.code_index  = code;
    p.event_byte0 = mb[0];
    p.event_byte1 = mb[1];
    p.event_byte2 = mb[2];
    p.last_event  = 1'b0;
    return p;
  endfunction

  // Parse one byte against the current status.
  always_comb begin
    cur_status_nxt = cur_status_r;
    byte_count_nxt = byte_count_r;
    msg_nxt        = msg_r;
    pkt_a          = '0;
    pkt_b          = '0;
    emit_a         = 1'b0;
    emit_b         = 1'b0;
    if (in_rx_byte >= REALTIME_FIRST) begin
      if (sys_len(in_rx_byte[3:0]) != 2'd0) begin
        pkt_a.code_index  = CIN_REALTIME;
        pkt_a.event_byte0 = in_rx_byte;
        emit_a            = 1'b1;
      end
    end else begin
      if (in_rx_byte[7]) begin
        // close an open sysex with an inserted end byte
        if (cur_status_nxt == STATUS_SYSEX) begin
          for (int i = 0; i < 3; i++) begin
            if (byte_count_nxt == i[1:0]) begin
              msg_nxt[i] = STATUS_EOX;
            end
          end
          if (byte_count_nxt != 2'd3) begin
            byte_count_nxt = byte_count_nxt + 2'd1;
          end
          pkt_a          = make_pkt(cur_status_nxt, byte_count_nxt, msg_nxt);
          emit_a         = 1'b1;
          msg_nxt        = '0;
          byte_count_nxt = 2'd0;
        end
        cur_status_nxt = in_rx_byte;
        byte_count_nxt = 2'd0;
        if (msg_len(in_rx_byte) == 2'd0) begin
          msg_nxt = '0;
        end
      end
      if (cur_status_nxt != 8'd0 && msg_len(cur_status_nxt) != 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          if (byte_count_nxt == i[1:0]) begin
            msg_nxt[i] = in_rx_byte;
          end
        end
        if (byte_count_nxt != 2'd3) begin
          byte_count_nxt = byte_count_nxt + 2'd1;
        end
        if (byte_count_nxt >= msg_len(cur_status_nxt)) begin
          pkt_b          = make_pkt(cur_status_nxt, byte_count_nxt, msg_nxt);
          emit_b         = 1'b1;
          msg_nxt        = '0;
          byte_count_nxt = 2'd0;
          // keep channel status for running status
          if (cur_status_nxt < STATUS_SYSTEM) begin
            msg_nxt[0]     = cur_status_nxt;
            byte_count_nxt = 2'd1;
          end
          if (cur_status_nxt > STATUS_SYSEX) begin
            cur_status_nxt = 8'd0;
          end
        end
      end
    end
    if (emit_b) begin
      pkt_b.last_event = 1'b1;
    end else if (emit_a) begin
      pkt_a.last_event = 1'b1;
    end
  end

  assign push0  = emit_a ? pkt_a : pkt_b;
  assign push1  = pkt_b;
  assign push_n = {1'b0, emit_a} + {1'b0, emit_b};

  assign in_stall  = (count_r > QCNT_W'(QUEUE_DEPTH - 2));
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
    end
    count_nxt = count_r + (in_fire ? QCNT_W'(push_n) : QCNT_W'(0))
                        - (out_fire ? QCNT_W'(1) : QCNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_status_r <= 8'd0;
      byte_count_r <= 2'd0;
      msg_r        <= '0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (in_fire) begin
        cur_status_r <= cur_status_nxt;
        byte_count_r <= byte_count_nxt;
        msg_r        <= msg_nxt;
      end
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && push_n != 2'd0) begin
      queue_r[wr_ptr_r] <= push0;
    end
    if (in_fire && push_n == 2'd2) begin
      queue_r[wr_ptr_p1] <= push1;
    end
  end

  assign out_code_index  = queue_r[rd_ptr_r].code_index;
  assign out_event_byte0 = queue_r[rd_ptr_r].event_byte0;
  assign out_event_byte1 = queue_r[rd_ptr_r].event_byte1;
  assign out_event_byte2 = queue_r[rd_ptr_r].event_byte2;
  assign out_last_event  = queue_r[rd_ptr_r].last_event;

endmodule

// ===== hdl/m2u_checker.sv =====
// Port-level assertions for the packetizer and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module m2u_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_code_index,
  input logic [7:0] out_event_byte0,
  input logic [7:0] out_event_byte1,
  input logic [7:0] out_event_byte2,
  input logic       out_last_event
);
  import m2u_pkg::*;

  pkt_t out_pkt;
  logic out_wait;
  logic rt_pkt;
  logic rt_form;

  assign out_pkt  = {out_code_index, out_event_byte0, out_event_byte1, out_event_byte2,
                     out_last_event};
  assign out_wait = out_valid && out_stall;
  assign rt_pkt   = out_valid && out_code_index == CIN_REALTIME;
  assign rt_form  = out_event_byte0 >= REALTIME_FIRST && out_event_byte1 == 8'd0 &&
                    out_event_byte2 == 8'd0 && out_last_event;

  // A stalled request holds until taken.
  `M2U_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_pkt), "stalled packet changed")

  // Queue empties on reset.
  `M2U_ASSERT(a_reset_empty, $rose(rst_n) |-> !out_valid, "packet present after reset")

  // Input is held off only while packets are queued.
  `M2U_ASSERT(a_stall_queued, in_stall |-> out_valid, "input stalled with empty queue")

  // Realtime packets carry a single realtime byte.
  `M2U_ASSERT(a_realtime_form, rt_pkt |-> rt_form, "malformed realtime packet")

endmodule

bind midi_to_usb_event_packetizer_core m2u_checker u_m2u_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the MIDI to USB-MIDI event packetizer core.
`timescale 1ns / 1ps

module tb_top;
  import m2u_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_ITEMS = 950;
  localparam int PREDICT      = -1;

  // Code index numbers
  localparam logic [3:0] CIN_COMMON2    = 4'd2;
  localparam logic [3:0] CIN_COMMON3    = 4'd3;
  localparam logic [3:0] CIN_ONE_BYTE   = 4'd5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'd6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'd7;
  localparam logic [3:0] CIN_NOTE_ON    = 4'd9;

  // Status bytes
  localparam logic [7:0] ST_CHAN_FIRST  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON     = 8'h90;
  localparam logic [7:0] ST_PROG_CHANGE = 8'hC5;
  localparam logic [7:0] ST_CHAN_LAST   = 8'hEF;
  localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4    = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5    = 8'hF5;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] RT_CLOCK       = 8'hF8;
  localparam logic [7:0] RT_UNDEF_F9    = 8'hF9;
  localparam logic [7:0] RT_SENSE       = 8'hFE;
  localparam logic [7:0] RT_RESET       = 8'hFF;

  localparam logic [1:0] CHAN_LEN [7] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3};
  localparam logic [1:0] SYS_LEN [16] = '{2'd3, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
                                          2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1};
  localparam logic [3:0] COMMON_CIN [3] = '{CIN_ONE_BYTE, CIN_COMMON2, CIN_COMMON3};
  localparam pkt_t NO_PKT = '0;

  typedef struct {
    logic [7:0] rx;
    int         n;
    pkt_t       first;
    pkt_t       second;
  } step_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_code_index;
  logic [7:0] out_event_byte0;
  logic [7:0] out_event_byte1;
  logic [7:0] out_event_byte2;
  logic       out_last_event;

  // Parser state mirrored by the predictor
  logic [7:0] cur_status = 8'h00;
  logic [1:0] held_count = 2'd0;
  logic [7:0] held_bytes [3] = '{8'h00, 8'h00, 8'h00};
  pkt_t       new_pkts [2];

  pkt_t       pending_packets [$];
  step_t      steps [$];
  logic [7:0] burst [$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         steady_left = 0;
  int         stall_left = 0;

  midi_to_usb_event_packetizer_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_index  (out_code_index),
    .out_event_byte0 (out_event_byte0),
    .out_event_byte1 (out_event_byte1),
    .out_event_byte2 (out_event_byte2),
    .out_last_event  (out_last_event)
  );

  always #5 clk = ~clk;

  function automatic logic [1:0] message_length(input logic [7:0] s);
    if (!s[7]) begin
      return 2'd0;
    end
    if (s < STATUS_SYSTEM) begin
      return CHAN_LEN[s[6:4]];
    end
    return SYS_LEN[s[3:0]];
  endfunction

  function automatic void hold_byte(input logic [7:0] b);
    if (held_count < 2'd3) begin
      held_bytes[held_count] = b;
      held_count++;
    end
  endfunction

  // Emit the assembled message as packet k and rearm for running status.
  function automatic void close_message(input int k);
    logic [7:0] s;
    logic [1:0] top;
    logic [3:0] cin;
    s = cur_status;
    top = (held_count == 2'd0) ? 2'd0 : held_count - 2'd1;
    if (s < STATUS_SYSTEM) begin
      cin = s[7:4];
    end else if (s == STATUS_SYSEX) begin
      cin = CIN_SYSEX + ((held_bytes[top] == STATUS_EOX) ? {2'b00, held_count} : 4'd0);
    end else if (s < REALTIME_FIRST) begin
      cin = COMMON_CIN[top];
    end else begin
      cin = CIN_REALTIME;
    end
    new_pkts[k] = {cin, held_bytes[0], held_bytes[1], held_bytes[2], 1'b0};
    held_bytes = '{8'h00, 8'h00, 8'h00};
    held_count = 2'd0;
    if (s < STATUS_SYSTEM) begin
      held_bytes[0] = s;
      held_count = 2'd1;
    end
    if (s > STATUS_SYSTEM) begin
      cur_status = 8'h00;
    end
  endfunction

  // Advance the parser by one byte; returns the number of packets in new_pkts.
  function automatic int parse_byte(input logic [7:0] b);
    int n;
    n = 0;
    if (b > STATUS_EOX) begin
      if (SYS_LEN[b[3:0]] != 2'd0) begin
        new_pkts[0] = {CIN_REALTIME, b, 8'h00, 8'h00, 1'b0};
        n = 1;
      end
    end else begin
      if (b[7]) begin
        // close an open sysex before taking the new status
        if (cur_status == STATUS_SYSEX) begin
          hold_byte(STATUS_EOX);
          close_message(n);
          n++;
        end
        cur_status = b;
        held_count = 2'd0;
        if (message_length(b) == 2'd0) begin
          held_bytes = '{8'h00, 8'h00, 8'h00};
        end
      end
      if (message_length(cur_status) != 2'd0) begin
        hold_byte(b);
        if (held_count >= message_length(cur_status)) begin
          close_message(n);
          n++;
        end
      end
    end
    if (n > 0) begin
      new_pkts[n - 1].last_event = 1'b1;
    end
    return n;
  endfunction

  function automatic logic [7:0] rand_data();
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic void add_step(input logic [7:0] rx, input int n, input pkt_t first,
                                   input pkt_t second);
    steps.push_back('{rx, n, first, second});
  endfunction

  task automatic report_packet(input string why, input pkt_t want, input pkt_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected cin %h bytes %h %h %h last %b, got cin %h bytes %h %h %h last %b",
               $time, why, want.code_index, want.event_byte0, want.event_byte1,
               want.event_byte2, want.last_event, got.code_index, got.event_byte0,
               got.event_byte1, got.event_byte2, got.last_event);
    end
  endtask

  // Present one byte, hold it until accepted, then queue its packets.
  task automatic send_byte(input logic [7:0] b, input int typed_n, input pkt_t t0,
                           input pkt_t t1);
    int gap;
    int r;
    int n;
    int k;
    if (steady_left > 0) begin
      gap = 0;
      steady_left--;
    end else begin
      r = $urandom_range(99);
      gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
      if (r == 0) begin
        steady_left = $urandom_range(30, 80);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    n = parse_byte(b);
    if (typed_n != PREDICT) begin
      n = typed_n;
      new_pkts[0] = t0;
      new_pkts[1] = t1;
    end
    for (k = 0; k < n; k++) begin
      pending_packets.push_back(new_pkts[k]);
    end
  endtask

  // Build one random message, mostly well formed, some noise.
  task automatic make_message();
    int kind;
    int cnt;
    logic [7:0] s;
    burst.delete();
    kind = $urandom_range(99);
    if (kind < 40) begin
      if (cur_status[7] && cur_status < STATUS_SYSTEM && $urandom_range(2) == 0) begin
        s = cur_status;
      end else begin
        s = 8'($urandom_range(ST_CHAN_FIRST, ST_CHAN_LAST));
        burst.push_back(s);
      end
      cnt = message_length(s) - 1;
      repeat (cnt) burst.push_back(rand_data());
    end else if (kind < 55) begin
      burst.push_back(STATUS_SYSEX);
      repeat ($urandom_range(0, 8)) burst.push_back(rand_data());
      if ($urandom_range(9) < 7) begin
        burst.push_back(STATUS_EOX);
      end else begin
        burst.push_back(8'($urandom_range(ST_CHAN_FIRST, STATUS_EOX)));
      end
    end else if (kind < 65) begin
      case ($urandom_range(3))
        0: s = ST_TIME_CODE;
        1: s = ST_SONG_POS;
        2: s = ST_SONG_SEL;
        default: s = ST_TUNE_REQ;
      endcase
      burst.push_back(s);
      cnt = message_length(s) - 1;
      repeat (cnt) burst.push_back(rand_data());
    end else if (kind < 72) begin
      burst.push_back(8'($urandom_range(REALTIME_FIRST, 8'hFF)));
    end else if (kind < 80) begin
      case ($urandom_range(2))
        0: burst.push_back(ST_UNDEF_F4);
        1: burst.push_back(ST_UNDEF_F5);
        default: burst.push_back(STATUS_EOX);
      endcase
      repeat ($urandom_range(2)) burst.push_back(rand_data());
    end else begin
      repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom_range(255)));
    end
    // drop a realtime byte somewhere into the message now and then
    if ($urandom_range(9) == 0) begin
      burst.insert($urandom_range(burst.size()), 8'($urandom_range(REALTIME_FIRST, 8'hFF)));
    end
  endtask

  always @(posedge clk) begin : take_packets
    pkt_t got;
    pkt_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_code_index, out_event_byte0, out_event_byte1, out_event_byte2, out_last_event};
      if (pending_packets.size() == 0) begin
        report_packet("packet with none pending", NO_PKT, got);
      end else begin
        want = pending_packets.pop_front();
        if (got !== want) begin
          report_packet("packet mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin : drive_stall
    int r;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(99);
      if (steady_left > 0 || r < 60) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int live_items;
    bit paused;
    live_items = 0;
    paused = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    out_stall <= 1'b0;

    add_step(8'h00, 0, NO_PKT, NO_PKT);
    add_step(8'h7F, 0, NO_PKT, NO_PKT);
    add_step(RT_CLOCK, 1, {CIN_REALTIME, RT_CLOCK, 8'h00, 8'h00, 1'b1}, NO_PKT);
    add_step(RT_UNDEF_F9, 0, NO_PKT, NO_PKT);
    add_step(ST_NOTE_ON, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h3C, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h7F, 1, {CIN_NOTE_ON, ST_NOTE_ON, 8'h3C, 8'h7F, 1'b1}, NO_PKT);
    add_step(8'h00, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h40, PREDICT, NO_PKT, NO_PKT);
    add_step(ST_PROG_CHANGE, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h7F, PREDICT, NO_PKT, NO_PKT);
    add_step(STATUS_SYSEX, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h01, PREDICT, NO_PKT, NO_PKT);
    add_step(RT_SENSE, 1, {CIN_REALTIME, RT_SENSE, 8'h00, 8'h00, 1'b1}, NO_PKT);
    add_step(8'h02, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h03, PREDICT, NO_PKT, NO_PKT);
    add_step(STATUS_EOX, 1, {CIN_SYSEX_END2, 8'h03, STATUS_EOX, 8'h00, 1'b1}, NO_PKT);
    add_step(ST_UNDEF_F4, 0, NO_PKT, NO_PKT);
    add_step(8'h12, 0, NO_PKT, NO_PKT);
    add_step(ST_SONG_POS, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h10, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h20, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h30, 0, NO_PKT, NO_PKT);
    add_step(STATUS_SYSEX, PREDICT, NO_PKT, NO_PKT);
    add_step(8'h7F, PREDICT, NO_PKT, NO_PKT);
    add_step(ST_TUNE_REQ, 2, {CIN_SYSEX_END3, STATUS_SYSEX, 8'h7F, STATUS_EOX, 1'b0},
             {CIN_ONE_BYTE, ST_TUNE_REQ, 8'h00, 8'h00, 1'b1});
    add_step(RT_RESET, 1, {CIN_REALTIME, RT_RESET, 8'h00, 8'h00, 1'b1}, NO_PKT);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      send_byte(steps[i].rx, steps[i].n, steps[i].first, steps[i].second);
    end

    while (live_items < RANDOM_ITEMS) begin
      make_message();
      foreach (burst[i]) begin
        // skip bytes the parser drops from the item count
        if (burst[i][7] ? !(burst[i] > STATUS_EOX && SYS_LEN[burst[i][3:0]] == 2'd0)
                        : message_length(cur_status) != 2'd0) begin
          live_items++;
        end
        send_byte(burst[i], PREDICT, NO_PKT, NO_PKT);
      end
      // hold the sender once until the packet queue has fully drained
      if (!paused && live_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_packets.size() != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_packets.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_packets.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/m2u_pkg.sv
hdl/midi_to_usb_event_packetizer_core.sv
hdl/m2u_checker.sv
tb/tb_top.sv
